// ===== rtl/gds_pkg.sv =====
// shared constants, payload types and helpers of the guarded delimiter splitter
package gds_pkg;

   localparam int MAX_DELIM_DEF   = 4;
   localparam int MAX_PAIRS_DEF   = 4;
   localparam int COUNT_WIDTH_DEF = 16;

   localparam int BYTE_W    = 8;
   localparam int REG_W     = 32;
   localparam int REG_BYTES = REG_W / BYTE_W;
   localparam int LEN_REG_W = 3;
   localparam int TOKEN_W   = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_DELIM_BYTES  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DELIM_LENGTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OPEN_CHARS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CLOSE_CHARS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PAIR_COUNT   = 3'd4;

   localparam logic [REG_W-1:0]     DELIM_BYTES_RST  = 32'd44;
   localparam logic [LEN_REG_W-1:0] DELIM_LENGTH_RST = 3'd1;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              is_last;
   } req_type;

   typedef struct packed {
      logic                 write;
      logic [CSR_IDX_W-1:0] index;
      logic [REG_W-1:0]     data;
   } csr_write_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               byte_valid;
      logic               token_end;
      logic [TOKEN_W-1:0] token_count;
      logic               too_short;
      logic               last;
   } rsp_type;

   function automatic logic [BYTE_W-1:0] byte_of(logic [REG_W-1:0] reg_word, int j);
      if (j >= REG_BYTES) return '0;
      return reg_word[BYTE_W*j +: BYTE_W];
   endfunction

endpackage

// ===== rtl/gds_if.sv =====
// beat channels of the guarded delimiter splitter: request, response and register write
interface gds_req_if;
   import gds_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              is_last;
   modport source (output valid, in_byte, is_last, input ready);
   modport sink   (input valid, in_byte, is_last, output ready);
endinterface

interface gds_rsp_if;
   import gds_pkg::*;
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  out_byte;
   logic               byte_valid;
   logic               token_end;
   logic [TOKEN_W-1:0] token_count;
   logic               too_short;
   logic               last;
   modport source (output valid, out_byte, byte_valid, token_end, token_count, too_short,
                   last, input ready);
   modport sink   (input valid, out_byte, byte_valid, token_end, token_count, too_short,
                   last, output ready);
endinterface

interface gds_csr_if;
   import gds_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [REG_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/gds_core.sv =====
// configuration registers, string state and the per-byte split step
module gds_core #(
   parameter int MAX_DELIM   = gds_pkg::MAX_DELIM_DEF,
   parameter int MAX_PAIRS   = gds_pkg::MAX_PAIRS_DEF,
   parameter int COUNT_WIDTH = gds_pkg::COUNT_WIDTH_DEF,
   parameter int MAX_RES     = MAX_DELIM + 1,
   parameter int RES_W       = $clog2(MAX_RES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gds_pkg::csr_write_type csr_write,
   input  logic                   item_accept,
   input  gds_pkg::req_type       item,
   output gds_pkg::rsp_type       res_list [MAX_RES],
   output logic [RES_W-1:0]       res_count
);
   import gds_pkg::*;

   localparam int LEN_W  = $clog2(MAX_DELIM + 1);
   localparam int PAIR_N = MAX_PAIRS + 1;
   localparam int PAIR_W = $clog2(MAX_PAIRS + 2);

   typedef rsp_type res_list_type [MAX_RES];

   logic [REG_W-1:0]     delim_bytes_ff, delim_bytes_in;
   logic [LEN_REG_W-1:0] delim_length_ff, delim_length_in;
   logic [REG_W-1:0]     open_chars_ff, open_chars_in;
   logic [REG_W-1:0]     close_chars_ff, close_chars_in;
   logic [LEN_REG_W-1:0] pair_count_ff, pair_count_in;
   logic                 cfg_hit;

   logic [BYTE_W-1:0]      win_ff [MAX_DELIM];
   logic [BYTE_W-1:0]      win_in [MAX_DELIM];
   logic [LEN_W-1:0]       fill_ff, fill_in;
   logic [PAIR_N-1:0]      flags_ff, flags_in;
   logic [LEN_W-1:0]       skip_ff, skip_in;
   logic [COUNT_WIDTH-1:0] tokens_ff, tokens_in;

   logic [LEN_W-1:0]  dl;
   logic [PAIR_W-1:0] np;
   logic              any_open;
   logic              matched;
   res_list_type      list_v;
   logic [RES_W-1:0]  n_v;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(logic [COUNT_WIDTH-1:0] v);
      if (v == '1) return v;
      return v + 1'b1;
   endfunction

   function automatic rsp_type mk_rsp(logic [BYTE_W-1:0] b, logic bv, logic te, logic sh,
                                      logic [COUNT_WIDTH-1:0] tok);
      rsp_type r;
      logic [TOKEN_W+COUNT_WIDTH-1:0] ext;
      ext           = {TOKEN_W'(0), tok};
      r.out_byte    = bv ? b : '0;
      r.byte_valid  = bv;
      r.token_end   = te;
      r.token_count = ext[TOKEN_W-1:0];
      r.too_short   = sh;
      r.last        = 1'b0;
      return r;
   endfunction

   function automatic res_list_type put(res_list_type l, logic [RES_W-1:0] n, rsp_type r);
      res_list_type o;
      o = l;
      for (int k = 0; k < MAX_RES; k++) begin
         if (int'(n) == k) o[k] = r;
      end
      return o;
   endfunction

   function automatic logic [PAIR_N-1:0] guard_check(logic [PAIR_N-1:0] f,
                                                     logic [BYTE_W-1:0] c);
      logic [PAIR_N-1:0] r;
      logic              hit;
      r   = f;
      hit = 1'b0;
      for (int j = 0; j < MAX_PAIRS; j++) begin
         if (!hit && j < int'(np)) begin
            if (!f[j] && c == byte_of(open_chars_ff, j)) begin
               r[j] = 1'b1;
               hit  = 1'b1;
            end else if (f[j] && c == byte_of(close_chars_ff, j)) begin
               r[j] = 1'b0;
               hit  = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // config registers
   always_comb begin
      delim_bytes_in  = delim_bytes_ff;
      delim_length_in = delim_length_ff;
      open_chars_in   = open_chars_ff;
      close_chars_in  = close_chars_ff;
      pair_count_in   = pair_count_ff;
      cfg_hit         = 1'b0;
      if (csr_write.write) begin
         cfg_hit = 1'b1;
         unique case (csr_write.index)
            REG_DELIM_BYTES:  delim_bytes_in  = csr_write.data;
            REG_DELIM_LENGTH: delim_length_in = csr_write.data[LEN_REG_W-1:0];
            REG_OPEN_CHARS:   open_chars_in   = csr_write.data;
            REG_CLOSE_CHARS:  close_chars_in  = csr_write.data;
            REG_PAIR_COUNT:   pair_count_in   = csr_write.data[LEN_REG_W-1:0];
            default:          cfg_hit         = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_bytes_ff  <= DELIM_BYTES_RST;
         delim_length_ff <= DELIM_LENGTH_RST;
         open_chars_ff   <= '0;
         close_chars_ff  <= '0;
         pair_count_ff   <= '0;
      end else begin
         delim_bytes_ff  <= delim_bytes_in;
         delim_length_ff <= delim_length_in;
         open_chars_ff   <= open_chars_in;
         close_chars_ff  <= close_chars_in;
         pair_count_ff   <= pair_count_in;
      end
   end

   // effective lengths
   always_comb begin
      if (delim_length_ff == '0) begin
         dl = LEN_W'(1);
      end else if (int'(delim_length_ff) > MAX_DELIM) begin
         dl = LEN_W'(MAX_DELIM);
      end else begin
         dl = LEN_W'(delim_length_ff);
      end
      if (int'(pair_count_ff) > MAX_PAIRS) begin
         np = PAIR_W'(MAX_PAIRS);
      end else begin
         np = PAIR_W'(pair_count_ff);
      end
   end

   always_comb begin
      any_open = 1'b0;
      for (int j = 0; j < MAX_PAIRS; j++) begin
         if (j < int'(np) && flags_ff[j]) any_open = 1'b1;
      end
   end

   // delimiter compare over held bytes plus the new byte
   always_comb begin
      logic [BYTE_W-1:0] last_d;
      last_d  = '0;
      matched = 1'b1;
      for (int i = 0; i < MAX_DELIM; i++) begin
         if (i < int'(dl) - 1 && win_ff[i] != byte_of(delim_bytes_ff, i)) matched = 1'b0;
         if (i == int'(dl) - 1) last_d = byte_of(delim_bytes_ff, i);
      end
      matched = matched && (item.in_byte == last_d);
   end

   // split step
   always_comb begin
      logic [BYTE_W-1:0]      c;
      logic [BYTE_W-1:0]      b;
      logic [LEN_W-1:0]       skip_v;
      logic [PAIR_N-1:0]      flags_v;
      logic [COUNT_WIDTH-1:0] tok;
      logic [BYTE_W-1:0]      win_v [MAX_DELIM];
      c         = item.in_byte;
      b         = '0;
      skip_v    = skip_ff;
      flags_v   = flags_ff;
      tok       = tokens_ff;
      win_v     = win_ff;
      win_in    = win_ff;
      fill_in   = fill_ff;
      flags_in  = flags_ff;
      skip_in   = skip_ff;
      tokens_in = tokens_ff;
      n_v       = '0;
      for (int k = 0; k < MAX_RES; k++) list_v[k] = '0;
      if (item_accept) begin
         if (int'(fill_ff) + 1 < int'(dl)) begin
            // window still filling
            for (int i = 0; i < MAX_DELIM; i++) begin
               if (int'(fill_ff) == i) win_in[i] = c;
            end
            fill_in = fill_ff + 1'b1;
            if (item.is_last) begin
               list_v    = put(list_v, n_v, mk_rsp('0, 1'b0, 1'b0, 1'b1, tokens_ff));
               n_v       = n_v + 1'b1;
               fill_in   = '0;
               flags_in  = '0;
               skip_in   = '0;
               tokens_in = '0;
            end
         end else begin
            if (skip_ff != '0) begin
               skip_v = skip_ff - 1'b1;
            end else if (!any_open && matched) begin
               tok     = sat_inc(tok);
               list_v  = put(list_v, n_v, mk_rsp('0, 1'b0, 1'b1, 1'b0, tok));
               n_v     = n_v + 1'b1;
               skip_v  = dl - LEN_W'(1);
               flags_v = guard_check(flags_ff, c);
            end else begin
               b       = (dl > LEN_W'(1)) ? win_ff[0] : c;
               list_v  = put(list_v, n_v, mk_rsp(b, 1'b1, 1'b0, 1'b0, tok));
               n_v     = n_v + 1'b1;
               flags_v = guard_check(flags_ff, b);
            end
            for (int i = 0; i < MAX_DELIM - 1; i++) begin
               if (i < int'(dl) - 2) begin
                  win_v[i] = win_ff[i+1];
               end else if (i == int'(dl) - 2) begin
                  win_v[i] = c;
               end
            end
            if (item.is_last) begin
               // flush held bytes that are not delimiter bytes, then end the token
               for (int i = 0; i < MAX_DELIM - 1; i++) begin
                  if (i < int'(dl) - 1 && i >= int'(skip_v)) begin
                     list_v = put(list_v, n_v, mk_rsp(win_v[i], 1'b1, 1'b0, 1'b0, tok));
                     n_v    = n_v + 1'b1;
                  end
               end
               tok       = sat_inc(tok);
               list_v    = put(list_v, n_v, mk_rsp('0, 1'b0, 1'b1, 1'b0, tok));
               n_v       = n_v + 1'b1;
               win_in    = win_v;
               fill_in   = '0;
               flags_in  = '0;
               skip_in   = '0;
               tokens_in = '0;
            end else begin
               win_in    = win_v;
               flags_in  = flags_v;
               skip_in   = skip_v;
               tokens_in = tok;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         fill_ff   <= '0;
         flags_ff  <= '0;
         skip_ff   <= '0;
         tokens_ff <= '0;
      end else begin
         fill_ff   <= fill_in;
         flags_ff  <= flags_in;
         skip_ff   <= skip_in;
         tokens_ff <= tokens_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign res_list  = list_v;
   assign res_count = n_v;

   a_fill_below_len: assert property (@(posedge clock) disable iff (reset)
      int'(fill_ff) < int'(dl))
      else $error("window fill reached delimiter length");

   a_skip_below_len: assert property (@(posedge clock) disable iff (reset)
      int'(skip_ff) < int'(dl))
      else $error("skip count reached delimiter length");

   a_tokens_step: assert property (@(posedge clock) disable iff (reset)
      tokens_ff == $past(tokens_ff) || tokens_ff == $past(tokens_ff) + 1'b1 ||
      tokens_ff == '0)
      else $error("token count moved by more than one");

endmodule

// ===== rtl/gds_emit.sv =====
// result buffer that holds one byte's results and issues them one beat at a time
module gds_emit #(
   parameter int MAX_RES = gds_pkg::MAX_DELIM_DEF + 1,
   parameter int RES_W   = $clog2(MAX_RES + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  gds_pkg::rsp_type list_in [MAX_RES],
   input  logic [RES_W-1:0] count_in,
   output logic             can_load,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gds_pkg::rsp_type rsp_data
);
   import gds_pkg::*;

   rsp_type          res_buf_ff [MAX_RES];
   logic [RES_W-1:0] cnt_ff, cnt_in;
   logic [RES_W-1:0] idx_ff, idx_in;
   logic             busy;
   logic             is_final;
   logic             pop;
   rsp_type          head;

   assign busy     = idx_ff != cnt_ff;
   assign is_final = busy && (idx_ff + 1'b1 == cnt_ff);
   assign pop      = busy && rsp_ready;
   assign can_load = !busy || (pop && is_final);

   always_comb begin
      head = res_buf_ff[0];
      for (int k = 0; k < MAX_RES; k++) begin
         if (int'(idx_ff) == k) head = res_buf_ff[k];
      end
      head.last = is_final;
   end

   assign rsp_valid = busy;
   assign rsp_data  = head;

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load) begin
         cnt_in = count_in;
         idx_in = '0;
      end else if (pop) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) res_buf_ff <= list_in;
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= cnt_ff)
      else $error("result index ran past result count");

   a_pop_advances: assert property (@(posedge clock) disable iff (reset)
      (pop && !is_final) |=> (busy && idx_ff == $past(idx_ff) + 1'b1))
      else $error("non-final beat did not advance to the next result");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (load && count_in != '0) |=> (rsp_valid && idx_ff == '0))
      else $error("loaded results not presented from the first");

endmodule

// ===== rtl/guarded_delimiter_splitter.sv =====
// top level of the guarded delimiter splitter
// Splits a byte stream into tokens at a delimiter of one to four bytes, ignoring
// delimiters inside open guard pairs. One request beat is taken per clock while
// each byte yields at most one response beat and the response side is ready, so
// ordinary text streams at one byte per cycle. The final byte of a string yields
// up to delim_length+1 response beats (its own result, held bytes, then the token
// end), issued one per cycle while the response side is ready; the next request
// is taken in the cycle the last of them is taken. The split step is combinational
// on the request beat; responses appear from the result buffer in the following
// cycle. Register writes are taken in any cycle, are meant for an idle block, and
// restart the string in progress. There is no clearing pass after reset.
module guarded_delimiter_splitter #(
   parameter int MAX_DELIM   = gds_pkg::MAX_DELIM_DEF,
   parameter int MAX_PAIRS   = gds_pkg::MAX_PAIRS_DEF,
   parameter int COUNT_WIDTH = gds_pkg::COUNT_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   gds_req_if.sink   req_if,
   gds_rsp_if.source rsp_if,
   gds_csr_if.sink   csr_if
);
   import gds_pkg::*;

   localparam int MAX_RES = MAX_DELIM + 1;
   localparam int RES_W   = $clog2(MAX_RES + 1);

   csr_write_type    csr_write;
   req_type          item;
   logic             item_accept;
   logic             can_load;
   rsp_type          res_list [MAX_RES];
   logic [RES_W-1:0] res_count;
   logic             rsp_valid;
   rsp_type          rsp_data;

   assign csr_if.ready    = 1'b1;
   assign csr_write.write = csr_if.valid;
   assign csr_write.index = csr_if.index;
   assign csr_write.data  = csr_if.data;

   assign item.in_byte = req_if.in_byte;
   assign item.is_last = req_if.is_last;
   assign req_if.ready = can_load;
   assign item_accept  = req_if.valid && can_load;

   gds_core #(
      .MAX_DELIM   (MAX_DELIM),
      .MAX_PAIRS   (MAX_PAIRS),
      .COUNT_WIDTH (COUNT_WIDTH),
      .MAX_RES     (MAX_RES),
      .RES_W       (RES_W)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .item_accept (item_accept),
      .item        (item),
      .res_list    (res_list),
      .res_count   (res_count)
   );

   gds_emit #(
      .MAX_RES (MAX_RES),
      .RES_W   (RES_W)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (item_accept),
      .list_in   (res_list),
      .count_in  (res_count),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_if.valid       = rsp_valid;
   assign rsp_if.out_byte    = rsp_data.out_byte;
   assign rsp_if.byte_valid  = rsp_data.byte_valid;
   assign rsp_if.token_end   = rsp_data.token_end;
   assign rsp_if.token_count = rsp_data.token_count;
   assign rsp_if.too_short   = rsp_data.too_short;
   assign rsp_if.last        = rsp_data.last;

endmodule
